@@ rtl/core/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared sizes, operation/status/error codes and the control structs that
// pass between the scheduler control, the ready chain and the status table.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int TID_W = 4;
  localparam int OP_W  = 2;
  localparam int ST_W  = 3;
  localparam int ERR_W = 2;

  localparam logic [OP_W-1:0] OP_SCHED   = 2'd0;
  localparam logic [OP_W-1:0] OP_BLOCK   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNBLOCK = 2'd2;
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd3;

  localparam logic [ST_W-1:0] ST_RUNNING = 3'd0;
  localparam logic [ST_W-1:0] ST_READY   = 3'd1;
  localparam logic [ST_W-1:0] ST_BLOCKED = 3'd2;
  localparam logic [ST_W-1:0] ST_HANGING = 3'd4;
  localparam logic [ST_W-1:0] ST_ABSENT  = 3'd5;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BAD   = 2'd3;

  // Command broadcast to every cell of the ready chain
  typedef struct packed {
    logic             shift_l;   // pop head: take right neighbor
    logic             shift_r;   // push head: take left neighbor
    logic             load_en;   // write load_id into the cell at load_pos
    logic [IDX_W-1:0] load_pos;
    logic [IDX_W-1:0] load_id;
  } chain_ctrl_t;

  // One write port of the status table
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [ST_W-1:0]  value;
  } stat_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/round_robin_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Status table plus a ready deque built as a row of cells; schedule, block,
// unblock and create commands, one result beat per command.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start / busy       operation, task_id, block_status
//  result    done (strobe)      running_task, switched, error_code
//
//  A command accepted at one edge is evaluated in the next cycle (status
//  read, deque move, table writes) and its result beat shows in the cycle
//  after. busy is high for the one evaluation cycle; a new command can be
//  taken in the cycle the result strobes. The receiver cannot stall.
//  Reset: task 0 running, all others absent, deque empty.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rrts_pkg::OP_W-1:0]   operation,
  input  wire logic [rrts_pkg::TID_W-1:0]  task_id,
  input  wire logic [rrts_pkg::ST_W-1:0]   block_status,
  output logic                             done,
  output logic      [rrts_pkg::TID_W-1:0]  running_task,
  output logic                             switched,
  output logic      [rrts_pkg::ERR_W-1:0]  error_code
);

  logic [rrts_pkg::OP_W-1:0]  op_q;
  logic [rrts_pkg::TID_W-1:0] tid_q;
  logic [rrts_pkg::ST_W-1:0]  bst_q;

  logic [rrts_pkg::CNT_W-1:0] cnt;
  logic [rrts_pkg::CNT_W-1:0] cnt_next;
  logic [rrts_pkg::IDX_W-1:0] cur;
  logic [rrts_pkg::IDX_W-1:0] cur_next;

  logic [rrts_pkg::ERR_W-1:0] err_next;
  logic                       sw_next;

  rrts_pkg::chain_ctrl_t      ctrl;
  rrts_pkg::chain_ctrl_t      ctrl_g;
  rrts_pkg::stat_wr_t         wr_a;
  rrts_pkg::stat_wr_t         wr_b;
  rrts_pkg::stat_wr_t         wr_a_g;
  rrts_pkg::stat_wr_t         wr_b_g;

  logic [rrts_pkg::IDX_W-1:0] head_id;
  logic [rrts_pkg::IDX_W-1:0] tid_idx;
  logic [rrts_pkg::IDX_W-1:0] rd_addr;
  logic [rrts_pkg::ST_W-1:0]  st;
  logic                       tid_ok;
  logic                       bst_ok;
  logic                       empty;
  logic                       full;

  assign tid_idx = rrts_pkg::IDX_W'(tid_q);
  assign tid_ok  = 32'(tid_q) < 32'(rrts_pkg::MAX_TASKS);
  assign bst_ok  = (bst_q >= rrts_pkg::ST_BLOCKED) && (bst_q <= rrts_pkg::ST_HANGING);
  assign empty   = (cnt == '0);
  assign full    = (cnt == rrts_pkg::CNT_W'(rrts_pkg::MAX_TASKS));
  assign rd_addr = (op_q == rrts_pkg::OP_SCHED || op_q == rrts_pkg::OP_BLOCK) ? cur : tid_idx;

  rrts_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl_g),
    .head_id (head_id)
  );

  rrts_status u_status (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd_status (st),
    .wr_a      (wr_a_g),
    .wr_b      (wr_b_g)
  );

  always_comb begin
    err_next = rrts_pkg::ERR_OK;
    sw_next  = 1'b0;
    cnt_next = cnt;
    cur_next = cur;
    ctrl     = '0;
    wr_a     = '0;
    wr_b     = '0;

    unique case (op_q)
      rrts_pkg::OP_SCHED: begin
        if (st == rrts_pkg::ST_RUNNING) begin
          if (full) begin
            err_next = rrts_pkg::ERR_FULL;
          end else begin
            sw_next = 1'b1;
            wr_a    = '{en: 1'b1, addr: cur, value: rrts_pkg::ST_READY};
            if (empty) begin
              // current task goes in and comes straight back out
              wr_b = '{en: 1'b1, addr: cur, value: rrts_pkg::ST_RUNNING};
            end else begin
              // pop head and append current in the same move
              ctrl.shift_l  = 1'b1;
              ctrl.load_en  = 1'b1;
              ctrl.load_pos = rrts_pkg::IDX_W'(cnt - rrts_pkg::CNT_W'(1));
              ctrl.load_id  = cur;
              wr_b          = '{en: 1'b1, addr: head_id, value: rrts_pkg::ST_RUNNING};
              cur_next      = head_id;
            end
          end
        end else if (empty) begin
          err_next = rrts_pkg::ERR_EMPTY;
        end else begin
          sw_next      = 1'b1;
          ctrl.shift_l = 1'b1;
          cnt_next     = cnt - rrts_pkg::CNT_W'(1);
          wr_b         = '{en: 1'b1, addr: head_id, value: rrts_pkg::ST_RUNNING};
          cur_next     = head_id;
        end
      end
      rrts_pkg::OP_BLOCK: begin
        if (!bst_ok) begin
          err_next = rrts_pkg::ERR_BAD;
        end else if (empty) begin
          err_next = rrts_pkg::ERR_EMPTY;
        end else begin
          sw_next      = 1'b1;
          wr_a         = '{en: 1'b1, addr: cur, value: bst_q};
          ctrl.shift_l = 1'b1;
          cnt_next     = cnt - rrts_pkg::CNT_W'(1);
          wr_b         = '{en: 1'b1, addr: head_id, value: rrts_pkg::ST_RUNNING};
          cur_next     = head_id;
        end
      end
      rrts_pkg::OP_UNBLOCK: begin
        if (!tid_ok) begin
          err_next = rrts_pkg::ERR_BAD;
        end else if (st == rrts_pkg::ST_READY) begin
          err_next = rrts_pkg::ERR_OK;
        end else if (st == rrts_pkg::ST_ABSENT || st == rrts_pkg::ST_RUNNING) begin
          err_next = rrts_pkg::ERR_BAD;
        end else if (full) begin
          err_next = rrts_pkg::ERR_FULL;
        end else begin
          ctrl.shift_r = 1'b1;
          ctrl.load_id = tid_idx;
          cnt_next     = cnt + rrts_pkg::CNT_W'(1);
          wr_a         = '{en: 1'b1, addr: tid_idx, value: rrts_pkg::ST_READY};
        end
      end
      rrts_pkg::OP_CREATE: begin
        if (!tid_ok || st != rrts_pkg::ST_ABSENT) begin
          err_next = rrts_pkg::ERR_BAD;
        end else if (full) begin
          err_next = rrts_pkg::ERR_FULL;
        end else begin
          ctrl.load_en  = 1'b1;
          ctrl.load_pos = rrts_pkg::IDX_W'(cnt);
          ctrl.load_id  = tid_idx;
          cnt_next      = cnt + rrts_pkg::CNT_W'(1);
          wr_a          = '{en: 1'b1, addr: tid_idx, value: rrts_pkg::ST_READY};
        end
      end
      default: begin
        err_next = rrts_pkg::ERR_BAD;
      end
    endcase
  end

  // Commit only in the evaluation cycle
  assign ctrl_g = busy ? ctrl : '0;
  assign wr_a_g = busy ? wr_a : '0;
  assign wr_b_g = busy ? wr_b : '0;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q  <= operation;
      tid_q <= task_id;
      bst_q <= block_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      done         <= 1'b0;
      cnt          <= '0;
      cur          <= '0;
      running_task <= '0;
      switched     <= 1'b0;
      error_code   <= rrts_pkg::ERR_OK;
    end else begin
      done <= 1'b0;
      if (busy) begin
        busy         <= 1'b0;
        done         <= 1'b1;
        cnt          <= cnt_next;
        cur          <= cur_next;
        running_task <= rrts_pkg::TID_W'(cur_next);
        switched     <= sw_next;
        error_code   <= err_next;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rrts_cell.sv @@
// ----------------------------------------------------------------------------
// Ready chain cell
// Holds one slot of the ready deque; shifts toward the head on a pop, toward
// the tail on a push at the head, or loads a new id when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_cell (
  input  wire logic                        clk,
  input  wire rrts_pkg::chain_ctrl_t       ctrl,
  input  wire logic [rrts_pkg::IDX_W-1:0]  pos,
  input  wire logic [rrts_pkg::IDX_W-1:0]  left_id,
  input  wire logic [rrts_pkg::IDX_W-1:0]  right_id,
  output logic      [rrts_pkg::IDX_W-1:0]  id
);

  logic hit;

  assign hit = ctrl.load_en && (ctrl.load_pos == pos);

  always_ff @(posedge clk) begin
    priority if (ctrl.shift_r) begin
      id <= left_id;
    end else if (ctrl.shift_l) begin
      id <= hit ? ctrl.load_id : right_id;
    end else if (hit) begin
      id <= ctrl.load_id;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rrts_chain.sv @@
// ----------------------------------------------------------------------------
// Ready chain
// Row of cells forming the ready deque; cell 0 is always the head.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_chain (
  input  wire logic                        clk,
  input  wire rrts_pkg::chain_ctrl_t       ctrl,
  output logic      [rrts_pkg::IDX_W-1:0]  head_id
);

  logic [rrts_pkg::IDX_W-1:0] slot [rrts_pkg::MAX_TASKS];

  for (genvar i = 0; i < rrts_pkg::MAX_TASKS; i++) begin : g_cell
    logic [rrts_pkg::IDX_W-1:0] left_id;
    logic [rrts_pkg::IDX_W-1:0] right_id;

    // New id enters at the head on a push at the head
    if (i == 0) begin : g_first
      assign left_id = ctrl.load_id;
    end else begin : g_mid_l
      assign left_id = slot[i-1];
    end

    if (i == rrts_pkg::MAX_TASKS - 1) begin : g_last
      assign right_id = slot[i];
    end else begin : g_mid_r
      assign right_id = slot[i+1];
    end

    rrts_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pos      (rrts_pkg::IDX_W'(i)),
      .left_id  (left_id),
      .right_id (right_id),
      .id       (slot[i])
    );
  end

  assign head_id = slot[0];

endmodule

`default_nettype wire

@@ rtl/core/rrts_status.sv @@
// ----------------------------------------------------------------------------
// Task status table
// One status register per task, one read address, two write ports; port b
// wins when both address the same task.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_status (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [rrts_pkg::IDX_W-1:0]  rd_addr,
  output logic      [rrts_pkg::ST_W-1:0]   rd_status,
  input  wire rrts_pkg::stat_wr_t          wr_a,
  input  wire rrts_pkg::stat_wr_t          wr_b
);

  logic [rrts_pkg::ST_W-1:0] status [rrts_pkg::MAX_TASKS];

  for (genvar i = 0; i < rrts_pkg::MAX_TASKS; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (rst) begin
        status[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_ABSENT;
      end else if (wr_b.en && wr_b.addr == rrts_pkg::IDX_W'(i)) begin
        status[i] <= wr_b.value;
      end else if (wr_a.en && wr_a.addr == rrts_pkg::IDX_W'(i)) begin
        status[i] <= wr_a.value;
      end
    end
  end

  assign rd_status = status[rd_addr];

endmodule

`default_nettype wire

@@ rtl/core/rrts_checker.sv @@
// ----------------------------------------------------------------------------
// Round-robin task scheduler checker
// Port-level checks on command timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [rrts_pkg::TID_W-1:0]  running_task,
  input wire logic                        switched,
  input wire logic [rrts_pkg::ERR_W-1:0]  error_code
);

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_result_timing : assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result beat not one cycle after evaluation");

  a_switch_ok : assert property (@(posedge clk) disable iff (rst)
    done && switched |-> error_code == rrts_pkg::ERR_OK)
    else $error("dispatch reported with an error");

  a_no_switch_hold : assert property (@(posedge clk) disable iff (rst)
    done && !switched |-> $stable(running_task))
    else $error("running task changed without a dispatch");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .running_task (running_task),
  .switched     (switched),
  .error_code   (error_code)
);

`default_nettype wire
